// ===== hw/rtl/ccp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ccp_pkg;

  // series length of the 2^-x evaluation and pipeline depths
  localparam int unsigned TERMS     = 24;
  localparam int unsigned GAMMA_LAT = 3 + 3 * TERMS + 2;
  localparam int unsigned LANE_LAT  = 5;

  // ln(2) in Q30 and the full blend weight
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [10:0] W_FULL  = 11'd1024;

  // running state of the exponential series, carried stage to stage
  typedef struct packed {
    logic [29:0] z;     // g*ln2 in Q30
    logic [4:0]  n;     // integer part of the exponent
    logic        lz;    // pixel luma is zero
    logic [30:0] term;  // current series term, Q30
    logic [31:0] sum;   // partial sum, Q30
  } exp_t;

  typedef logic [255:0][30:0] nl_tab_t;
  typedef logic [255:0][31:0] e_tab_t;
  typedef logic [255:0][17:0] rcp_tab_t;

  // bitwise long division, used only while building tables
  function automatic logic [63:0] ccp_udiv(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // log2 of an 8-bit value in unsigned Q28, by repeated squaring
  function automatic logic [63:0] ccp_lg_q28(input logic [7:0] v);
    logic [63:0] y;
    logic [63:0] frac;
    logic [2:0]  k;
    k    = '0;
    frac = '0;
    for (int i = 1; i < 8; i++) begin
      if (v[i]) begin
        k = 3'(i);
      end
    end
    y = 64'(v) << (30 - int'(k));
    for (int i = 0; i < 28; i++) begin
      y    = (y * y) >> 30;
      frac = frac << 1;
      if (y >= (64'd1 << 31)) begin
        frac = frac | 64'd1;
        y    = y >> 1;
      end
    end
    return (v == 8'd0) ? 64'd0 : ((64'(k) << 28) | frac);
  endfunction

  // 2^-x with x in Q28, result in Q30
  function automatic logic [63:0] ccp_pow2neg_q30(input logic [63:0] x);
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] g;
    logic [63:0] z;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] r;
    n    = x >> 28;
    f    = x & ((64'd1 << 28) - 64'd1);
    g    = (64'd1 << 28) - f;
    z    = (g * 64'(LN2_Q30)) >> 28;
    sum  = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int k = 1; k <= int'(TERMS); k++) begin
      term = ccp_udiv((term * z) >> 30, 64'(k));
      sum  = sum + term;
    end
    r = (n + 64'd1 >= 64'd40) ? 64'd0 : (sum >> (n + 64'd1));
    if (r > (64'd1 << 30)) begin
      r = 64'd1 << 30;
    end
    return r;
  endfunction

  // log2(255) - log2(luma), floored at zero
  function automatic nl_tab_t ccp_nl_tab();
    nl_tab_t     tab;
    logic [63:0] l255;
    logic [63:0] ll;
    l255 = ccp_lg_q28(8'd255);
    for (int l = 0; l < 256; l++) begin
      ll     = ccp_lg_q28(8'(l));
      tab[l] = (ll > l255) ? 31'd0 : 31'(l255 - ll);
    end
    return tab;
  endfunction

  // gamma exponent 2^(2m/255-1) scaled to Q30 (times two of 2^-d)
  function automatic e_tab_t ccp_e_tab();
    e_tab_t      tab;
    logic [63:0] d;
    for (int m = 0; m < 256; m++) begin
      d      = ccp_udiv(64'(510 - 2 * m) << 28, 64'd255);
      tab[m] = 32'(ccp_pow2neg_q30(d) << 1);
    end
    return tab;
  endfunction

  // reciprocal of luma+1 in Q17, floored
  function automatic rcp_tab_t ccp_rcp_tab();
    rcp_tab_t tab;
    for (int l = 0; l < 256; l++) begin
      tab[l] = 18'(ccp_udiv(64'd1 << 17, 64'(l + 1)));
    end
    return tab;
  endfunction

  localparam nl_tab_t  NL_TAB  = ccp_nl_tab();
  localparam e_tab_t   E_TAB   = ccp_e_tab();
  localparam rcp_tab_t RCP_TAB = ccp_rcp_tab();

endpackage

`default_nettype wire

// ===== hw/rtl/ccp_exp_term.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ccp_exp_term #(
  parameter int unsigned K = 1
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  ccp_pkg::exp_t  st_i,
  output ccp_pkg::exp_t  st_o
);
  import ccp_pkg::*;

  localparam logic [30:0] RECIP_K = 31'((64'd1 << 30) / K);
  localparam logic [4:0]  K_W     = 5'(K);

  exp_t        a_d;
  exp_t        a_q;
  exp_t        b_q;
  exp_t        c_d;
  exp_t        c_q;
  logic [60:0] tz_prod;
  logic [60:0] pq_prod;
  logic [29:0] q0_d;
  logic [29:0] q0_q;
  logic [34:0] qk;
  logic [34:0] rem;
  logic [29:0] q_fix;

  // term times z, back to Q30
  always_comb begin
    tz_prod  = 61'(st_i.term) * 61'(st_i.z);
    a_d      = st_i;
    a_d.term = {1'b0, tz_prod[59:30]};
  end

  // quotient estimate by reciprocal, at most one low
  always_comb begin
    pq_prod = 61'(a_q.term[29:0]) * 61'(RECIP_K);
    q0_d    = pq_prod[59:30];
  end

  // fix up the estimate and accumulate
  always_comb begin
    qk       = 35'(q0_q) * 35'(K_W);
    rem      = 35'(b_q.term[29:0]) - qk;
    q_fix    = q0_q + 30'(rem >= 35'(K_W));
    c_d      = b_q;
    c_d.term = {1'b0, q_fix};
    c_d.sum  = b_q.sum + 32'(q_fix);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q  <= a_d;
      b_q  <= a_q;
      q0_q <= q0_d;
      c_q  <= c_d;
    end
  end

  assign st_o = c_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ccp_gamma.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ccp_gamma (
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [7:0] luma_i,
  input  logic [7:0] mask_i,
  output logic [7:0] v_o
);
  import ccp_pkg::*;

  logic [30:0] nl_q;
  logic [31:0] e_q;
  logic        lz1_q;
  logic [62:0] ex_prod;
  logic [32:0] x_q;
  logic        lz2_q;
  logic [28:0] g;
  logic [58:0] gz_prod;
  exp_t        st0_d;
  exp_t        st0_q;
  exp_t        chain [TERMS+1];
  logic [5:0]  shamt;
  logic [31:0] shifted;
  logic [30:0] r_d;
  logic [30:0] r_q;
  logic        lz_e_q;
  logic [38:0] v_full;
  logic [7:0]  v_q;

  // exponent: log ratio times gamma
  always_comb begin
    ex_prod = 63'(e_q) * 63'(nl_q);
  end

  // split exponent, seed the series with z = g*ln2
  always_comb begin
    g          = 29'h1000_0000 - {1'b0, x_q[27:0]};
    gz_prod    = 59'(g) * 59'(LN2_Q30);
    st0_d.z    = gz_prod[57:28];
    st0_d.n    = x_q[32:28];
    st0_d.lz   = lz2_q;
    st0_d.term = 31'h4000_0000;
    st0_d.sum  = 32'h4000_0000;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nl_q  <= NL_TAB[luma_i];
      e_q   <= E_TAB[mask_i];
      lz1_q <= (luma_i == 8'd0);
      x_q   <= ex_prod[62:30];
      lz2_q <= lz1_q;
      st0_q <= st0_d;
    end
  end

  // exponential series, one term per three stages
  assign chain[0] = st0_q;

  for (genvar i = 0; i < TERMS; i++) begin : g_term
    ccp_exp_term #(
      .K(i + 1)
    ) u_term (
      .clk_i(clk_i),
      .en_i (en_i),
      .st_i (chain[i]),
      .st_o (chain[i+1])
    );
  end

  // scale by 2^-(n+1) and saturate at one
  always_comb begin
    shamt   = {1'b0, chain[TERMS].n} + 6'd1;
    shifted = chain[TERMS].sum >> shamt;
    r_d     = (shifted > 32'h4000_0000) ? 31'h4000_0000 : shifted[30:0];
  end

  // round to 8 bits
  always_comb begin
    v_full = 39'(r_q) * 39'd255 + (39'd1 << 29);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q    <= r_d;
      lz_e_q <= chain[TERMS].lz;
      v_q    <= lz_e_q ? 8'd0 : v_full[37:30];
    end
  end

  assign v_o = v_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ccp_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ccp_lane (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [7:0]  v_i,
  input  logic [7:0]  c_i,
  input  logic [7:0]  luma_i,
  input  logic [10:0] w_i,
  output logic [7:0]  chan_o
);
  import ccp_pkg::*;

  logic [16:0]        num_d;
  logic [16:0]        num1_q;
  logic [17:0]        rcp1_q;
  logic [7:0]         c1_q;
  logic [7:0]         l1_q;
  logic [34:0]        nr_prod;
  logic [16:0]        q0_q;
  logic [16:0]        num2_q;
  logic [7:0]         c2_q;
  logic [7:0]         l2_q;
  logic [8:0]         den;
  logic [25:0]        qd;
  logic [25:0]        rem;
  logic [16:0]        q_d;
  logic [16:0]        q3_q;
  logic [7:0]         c3_q;
  logic [7:0]         l3_q;
  logic signed [18:0] s;
  logic [7:0]         t_d;
  logic [7:0]         t_q;
  logic [7:0]         c4_q;
  logic [18:0]        p1_q;
  logic [18:0]        p2_q;
  logic [18:0]        blend;

  // v*(c+L)
  always_comb begin
    num_d = 17'(v_i) * 17'(9'(c_i) + 9'(luma_i));
  end

  // quotient estimate through reciprocal of L+1
  always_comb begin
    nr_prod = 35'(num1_q) * 35'(rcp1_q);
  end

  // correct the estimate by at most one
  always_comb begin
    den = 9'(l2_q) + 9'd1;
    qd  = 26'(q0_q) * 26'(den);
    rem = 26'(num2_q) - qd;
    q_d = q0_q + 17'(rem >= 26'(den));
  end

  // s = q + c - L, halve and clamp to 0..255
  always_comb begin
    s = $signed(19'(q3_q)) + $signed(19'(c3_q)) - $signed(19'(l3_q));
    if (s[18]) begin
      t_d = 8'd0;
    end else if (s[17:1] > 17'd255) begin
      t_d = 8'd255;
    end else begin
      t_d = s[8:1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num1_q <= num_d;
      rcp1_q <= RCP_TAB[luma_i];
      c1_q   <= c_i;
      l1_q   <= luma_i;
      q0_q   <= nr_prod[33:17];
      num2_q <= num1_q;
      c2_q   <= c1_q;
      l2_q   <= l1_q;
      q3_q   <= q_d;
      c3_q   <= c2_q;
      l3_q   <= l2_q;
      t_q    <= t_d;
      c4_q   <= c3_q;
      p1_q   <= 19'(t_q) * 19'(w_i);
      p2_q   <= 19'(W_FULL - w_i) * 19'(c4_q);
    end
  end

  // blend of corrected and original, out of 1024
  assign blend  = p1_q + p2_q;
  assign chan_o = blend[17:10];

endmodule

`default_nettype wire

// ===== hw/rtl/local_color_correction_pixel_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel      | handshake              | payload
// s_axis       | s_axis_tvalid/tready   | s_axis_tdata: red, green, blue, alpha, luma, mask
// m_axis       | m_axis_tvalid/tready   | m_axis_tdata: red, green, blue, alpha
// cfg          | cfg_wr_en_i            | cfg_wr_data_i: strength weight, 0..1024
//
// One pixel per clock sustained while the output is not stalled.
// Most of the pipeline depth comes from the 24-term exponential series, three stages per term.
// Reset clears the valid bits and the skid flag and sets the weight to 1024.
// A stalled output freezes the whole pipeline; the input skid takes one more pixel.
module local_color_correction_pixel_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [10:0] cfg_wr_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // red, green, blue, alpha, luma, mask
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // red, green, blue, alpha
);
  import ccp_pkg::*;

  localparam int unsigned TOTAL_LAT = GAMMA_LAT + LANE_LAT;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] luma;
  } pix_t;

  logic [10:0]          w_q;
  logic                 skid_full_d;
  logic                 skid_full_q;
  logic [47:0]          skid_q;
  logic                 adv;
  logic                 fr_valid;
  logic [47:0]          fr_data;
  pix_t                 fr_pix;
  logic [TOTAL_LAT-1:0] vld_q;
  pix_t                 pix_q [GAMMA_LAT];
  logic [7:0]           alpha_q [LANE_LAT];
  logic [7:0]           v;
  logic [7:0]           chan_src [3];
  logic [7:0]           chan [3];
  logic                 m_valid_q;
  logic [31:0]          m_data_q;

  // strength weight, saturated at 1024 on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= W_FULL;
    end else if (cfg_wr_en_i) begin
      w_q <= (cfg_wr_data_i > W_FULL) ? W_FULL : cfg_wr_data_i;
    end
  end

  // pipeline moves when the output register is free or being taken
  assign adv = !m_valid_q || m_axis_tready;

  // input skid: holds one transaction while the pipeline is frozen
  always_comb begin
    skid_full_d = skid_full_q;
    if (skid_full_q) begin
      if (adv) begin
        skid_full_d = 1'b0;
      end
    end else if (s_axis_tvalid && !adv) begin
      skid_full_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_full_q <= 1'b0;
    end else begin
      skid_full_q <= skid_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_full_q && s_axis_tvalid && !adv) begin
      skid_q <= s_axis_tdata;
    end
  end

  assign s_axis_tready = !skid_full_q;
  assign fr_valid      = skid_full_q || s_axis_tvalid;
  assign fr_data       = skid_full_q ? skid_q : s_axis_tdata;

  // unpack the front pixel
  always_comb begin
    fr_pix.red   = fr_data[7:0];
    fr_pix.green = fr_data[15:8];
    fr_pix.blue  = fr_data[23:16];
    fr_pix.alpha = fr_data[31:24];
    fr_pix.luma  = fr_data[39:32];
  end

  // gamma value from luma and mask
  ccp_gamma u_gamma (
    .clk_i (clk_i),
    .en_i  (adv),
    .luma_i(fr_data[39:32]),
    .mask_i(fr_data[47:40]),
    .v_o   (v)
  );

  // valid line and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      m_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[TOTAL_LAT-2:0], fr_valid};
      m_valid_q <= vld_q[TOTAL_LAT-1];
    end
  end

  // pixel delay alongside the gamma pipeline, alpha alongside the lanes
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pix_q[0] <= fr_pix;
      for (int i = 1; i < int'(GAMMA_LAT); i++) begin
        pix_q[i] <= pix_q[i-1];
      end
      alpha_q[0] <= pix_q[GAMMA_LAT-1].alpha;
      for (int i = 1; i < int'(LANE_LAT); i++) begin
        alpha_q[i] <= alpha_q[i-1];
      end
    end
  end

  // one lane per color channel
  always_comb begin
    chan_src[0] = pix_q[GAMMA_LAT-1].red;
    chan_src[1] = pix_q[GAMMA_LAT-1].green;
    chan_src[2] = pix_q[GAMMA_LAT-1].blue;
  end

  for (genvar j = 0; j < 3; j++) begin : g_lane
    ccp_lane u_lane (
      .clk_i (clk_i),
      .en_i  (adv),
      .v_i   (v),
      .c_i   (chan_src[j]),
      .luma_i(pix_q[GAMMA_LAT-1].luma),
      .w_i   (w_q),
      .chan_o(chan[j])
    );
  end

  // merge lanes and alpha into the output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_data_q <= {alpha_q[LANE_LAT-1], chan[2], chan[1], chan[0]};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

// ===== verif/pixel_correction_checker.sv =====
`timescale 1ns / 1ps

module pixel_correction_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [10:0] cfg_wr_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [47:0] s_tdata_i,   // red, green, blue, alpha, luma, mask
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,   // red, green, blue, alpha
  output int          mismatches_o,
  output int          outstanding_o
);

  localparam logic [63:0] LN2_Q30      = 64'd744261118;
  localparam logic [63:0] Q28_ONE      = 64'd1 << 28;
  localparam logic [63:0] Q30_ONE      = 64'd1 << 30;
  localparam int unsigned FULL_WEIGHT  = 1024;
  localparam int unsigned SERIES_TERMS = 24;

  // first declared field sits in the top bits
  typedef struct packed {
    logic [7:0] mask;
    logic [7:0] luma;
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_out_t;

  pixel_out_t  corrected_q[$];
  int unsigned weight;

  // log2 of an 8-bit value in Q28, fraction bits by repeated squaring
  function automatic logic [63:0] log2_q28(input logic [7:0] value);
    int unsigned msb;
    logic [63:0] mant;
    logic [63:0] frac;
    msb  = 0;
    frac = '0;
    for (int i = 1; i < 8; i++) begin
      if (value[i]) begin
        msb = i;
      end
    end
    mant = 64'(value) << (30 - msb);
    for (int i = 0; i < 28; i++) begin
      mant = (mant * mant) >> 30;
      frac = frac << 1;
      if (mant >= (64'd1 << 31)) begin
        frac = frac | 64'd1;
        mant = mant >> 1;
      end
    end
    return (64'(msb) << 28) | frac;
  endfunction

  // 2^-x for x in Q28, result in Q30, by a truncated exp series
  function automatic logic [63:0] exp2_neg_q30(input logic [63:0] x);
    logic [63:0] whole;
    logic [63:0] z;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] res;
    whole = x >> 28;
    z     = ((Q28_ONE - (x & (Q28_ONE - 64'd1))) * LN2_Q30) >> 28;
    term  = Q30_ONE;
    sum   = Q30_ONE;
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      term = ((term * z) >> 30) / 64'(k);
      sum  = sum + term;
    end
    if (whole + 64'd1 >= 64'd40) begin
      return 64'd0;
    end
    res = sum >> (whole + 64'd1);
    return (res > Q30_ONE) ? Q30_ONE : res;
  endfunction

  // corrected luma level: 255 * (luma/255) ^ (2 ^ (2*mask/255 - 1)), rounded
  function automatic int unsigned gamma_level(input int unsigned luma, input int unsigned mask);
    logic [63:0] lg_full;
    logic [63:0] lg_pix;
    logic [63:0] log_gap;
    logic [63:0] expo;
    logic [63:0] prod;
    logic [63:0] ratio;
    if (luma == 0) begin
      return 0;
    end
    lg_full = log2_q28(8'd255);
    lg_pix  = log2_q28(8'(luma));
    log_gap = (lg_pix > lg_full) ? 64'd0 : lg_full - lg_pix;
    expo    = 64'd2 * exp2_neg_q30((64'(510 - 2 * mask) << 28) / 64'd255);
    prod    = (expo * log_gap) >> 30;
    ratio   = exp2_neg_q30(prod);
    return int'((ratio * 64'd255 + (64'd1 << 29)) >> 30);
  endfunction

  // scale one channel by the luma ratio, then blend with the source
  function automatic logic [7:0] blend_channel(input int unsigned chan, input int unsigned luma,
                                               input int unsigned level, input int unsigned w);
    int          scaled;
    int unsigned fixed;
    scaled = int'((level * (chan + luma)) / (luma + 1)) + int'(chan) - int'(luma);
    if (scaled < 0) begin
      fixed = 0;
    end else begin
      fixed = int'(scaled) / 2;
      if (fixed > 255) begin
        fixed = 255;
      end
    end
    return 8'((fixed * w + (FULL_WEIGHT - w) * chan) >> 10);
  endfunction

  function automatic pixel_out_t correct_pixel(input pixel_in_t pix, input int unsigned w);
    pixel_out_t  res;
    int unsigned level;
    level     = gamma_level(pix.luma, pix.mask);
    res.red   = blend_channel(pix.red, pix.luma, level, w);
    res.green = blend_channel(pix.green, pix.luma, level, w);
    res.blue  = blend_channel(pix.blue, pix.luma, level, w);
    res.alpha = pix.alpha;
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches_o++;
    end
  endtask

  // track the weight, queue predictions, compare each output transaction
  always @(posedge clk_i) begin : monitor
    pixel_out_t got;
    pixel_out_t want;
    if (!rst_ni) begin
      weight = FULL_WEIGHT;
      corrected_q.delete();
      outstanding_o = 0;
    end else begin
      if (cfg_wr_en_i) begin
        weight = (cfg_wr_data_i > FULL_WEIGHT) ? FULL_WEIGHT : cfg_wr_data_i;
      end
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i;
        if (corrected_q.size() == 0) begin
          $error("output transaction with no pixel outstanding: %h", got);
          mismatches_o++;
        end else begin
          want = corrected_q.pop_front();
          compare_field("red_out", want.red, got.red);
          compare_field("green_out", want.green, got.green);
          compare_field("blue_out", want.blue, got.blue);
          compare_field("alpha_out", want.alpha, got.alpha);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        corrected_q.push_back(correct_pixel(s_tdata_i, weight));
      end
      outstanding_o = corrected_q.size();
    end
  end

endmodule

// ===== verif/local_color_correction_pixel_unit_test.sv =====
`timescale 1ns / 1ps

module local_color_correction_pixel_unit_test;

  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned DRAIN_CYCLES     = 100;
  localparam int unsigned PIXELS_PER_PHASE = 128;
  localparam int unsigned IDLE_PERCENT     = 22;
  localparam int unsigned PHASES           = 8;
  localparam int unsigned CALM_PHASE       = 3;

  // packed pick lists, entry 0 in the low bits
  localparam logic [31:0] LUMA_PICKS = {8'd255, 8'd128, 8'd1, 8'd0};
  localparam logic [23:0] MASK_PICKS = {8'd255, 8'd128, 8'd0};
  localparam logic [95:0] RGB_PICKS  = {8'd1, 8'd254, 8'd127, 8'd255, 8'd0, 8'd128,
                                        8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0};
  localparam logic [23:0] ALPHA_PICKS = {8'h5a, 8'd255, 8'd0};
  localparam logic [87:0] WEIGHT_STEPS = {11'd1024, 11'd0, 11'd512, 11'd1, 11'd1023,
                                          11'd1025, 11'd2047, 11'd0};

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_wr_en_i   = 1'b0;
  logic [10:0] cfg_wr_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic [47:0] s_axis_tdata  = '0;
  logic        m_axis_tready = 1'b0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [31:0] m_axis_tdata;

  int          mismatches;
  int          outstanding;
  int unsigned cycles = 0;
  bit          calm   = 1'b0;

  always #4 clk_i = ~clk_i;

  local_color_correction_pixel_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_wr_data_i(cfg_wr_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  pixel_correction_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_wr_data_i(cfg_wr_data_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding)
  );

  // output side back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [47:0] pack_pixel(input logic [7:0] red, input logic [7:0] green,
                                             input logic [7:0] blue, input logic [7:0] alpha,
                                             input logic [7:0] luma, input logic [7:0] mask);
    return {mask, luma, alpha, blue, green, red};
  endfunction

  // mostly uniform, with the range ends favored
  function automatic logic [7:0] random_level();
    if ($urandom_range(99) < 15) begin
      case ($urandom_range(3))
        0:       return 8'd0;
        1:       return 8'd1;
        2:       return 8'd254;
        default: return 8'd255;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  // one input transaction, with an optional idle gap ahead of it
  task automatic send_pixel(input logic [47:0] word);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
  endtask

  task automatic set_weight(input logic [10:0] weight);
    wait_drained();
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= weight;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
  endtask

  initial begin
    int unsigned idx;
    logic [87:0] steps;
    logic [23:0] rgb;
    steps = WEIGHT_STEPS;
    steps[6 * 11 +: 11] = 11'($urandom_range(2047));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pixels at the reset weight: luma and mask extremes, zero luma
    idx = 0;
    for (int li = 0; li < 4; li++) begin
      for (int mi = 0; mi < 3; mi++) begin
        rgb = RGB_PICKS[(idx % 4) * 24 +: 24];
        send_pixel(pack_pixel(rgb[23:16], rgb[15:8], rgb[7:0], ALPHA_PICKS[(idx % 3) * 8 +: 8],
                              LUMA_PICKS[li * 8 +: 8], MASK_PICKS[mi * 8 +: 8]));
        idx++;
      end
    end
    send_pixel(pack_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0));
    send_pixel(pack_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255));
    send_pixel(pack_pixel(random_level(), random_level(), random_level(), 8'd17, 8'd200, 8'd40));
    send_pixel(pack_pixel(random_level(), random_level(), random_level(), 8'd99, 8'd30, 8'd220));
    send_pixel(pack_pixel(random_level(), random_level(), random_level(), 8'd3, 8'd254, 8'd1));
    send_pixel(pack_pixel(random_level(), random_level(), random_level(), 8'd250, 8'd2, 8'd254));
    send_pixel(pack_pixel(8'd200, 8'd100, 8'd50, 8'd128, 8'd127, 8'd127));

    // random pixels over a series of weights, above-range ones included
    for (int ph = 0; ph < PHASES; ph++) begin
      set_weight(steps[ph * 11 +: 11]);
      calm <= (ph == CALM_PHASE);
      for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
        send_pixel(pack_pixel(random_level(), random_level(), random_level(),
                              8'($urandom_range(255)), random_level(), random_level()));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ccp_pkg.sv
hw/rtl/ccp_exp_term.sv
hw/rtl/ccp_gamma.sv
hw/rtl/ccp_lane.sv
hw/rtl/local_color_correction_pixel_unit.sv
verif/pixel_correction_checker.sv
verif/local_color_correction_pixel_unit_test.sv
